>>> rtl/cita_pkg.sv
// ----------------------------------------------------------------------------
// cita_pkg
// Operation codes shared by the typed integer ALU.
// ----------------------------------------------------------------------------
package cita_pkg;

  localparam int unsigned CMD_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_MUL   = 5'd0,
    CMD_DIV   = 5'd1,
    CMD_MOD   = 5'd2,
    CMD_ADD   = 5'd3,
    CMD_SUB   = 5'd4,
    CMD_SHL   = 5'd5,
    CMD_SHR   = 5'd6,
    CMD_LT    = 5'd7,
    CMD_LE    = 5'd8,
    CMD_GT    = 5'd9,
    CMD_GE    = 5'd10,
    CMD_EQ    = 5'd11,
    CMD_NE    = 5'd12,
    CMD_AND   = 5'd13,
    CMD_XOR   = 5'd14,
    CMD_OR    = 5'd15,
    CMD_LAND  = 5'd16,
    CMD_LOR   = 5'd17,
    CMD_NEG   = 5'd18,
    CMD_COMPL = 5'd19,
    CMD_LNOT  = 5'd20
  } cmd_e;

endpackage

>>> rtl/c_intmax_typed_alu_core.sv
// ----------------------------------------------------------------------------
// c_intmax_typed_alu_core
// Typed integer ALU with C usual arithmetic conversions, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | cmd, a/b value + unsigned, evaluating
//  out     | output    | out_valid_o / out_stall_i | result_value, result_unsigned, divide_error
//
//  One word enters every cycle unless a stalled output holds the pipeline.
//  The depth is set by the restoring divider, one quotient bit per stage.
//  The multiplier uses three half-width partial products, summed a stage later.
//  Reset clears all valid bits. A stalled output freezes the whole pipeline,
//  so in_stall_o rises only while a finished word waits at the output.
// ----------------------------------------------------------------------------
module c_intmax_typed_alu_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  cmd_i,
  input  logic [63:0] a_value_i,
  input  logic        a_unsigned_i,
  input  logic [63:0] b_value_i,
  input  logic        b_unsigned_i,
  input  logic        evaluating_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_value_o,
  output logic        result_unsigned_o,
  output logic        divide_error_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned SW = $clog2(W);
  localparam int unsigned L  = (W + 1) / 2;
  localparam int unsigned HB = W - L;

  typedef struct packed {
    cita_pkg::cmd_e cmd;
    logic [W-1:0]   res;
    logic           ru;
    logic           err;
    logic           dz;
    logic           qneg;
    logic           rneg;
  } side_t;

  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // input register
  logic           v0_q;
  cita_pkg::cmd_e cmd0_q;
  logic [W-1:0]   ua0_q, ub0_q;
  logic           au0_q, bu0_q, ev0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd0_q <= cita_pkg::cmd_e'(cmd_i);
      ua0_q  <= a_value_i[W-1:0];
      ub0_q  <= b_value_i[W-1:0];
      au0_q  <= a_unsigned_i;
      bu0_q  <= b_unsigned_i;
      ev0_q  <= evaluating_i;
    end
  end

  // stage 1: simple ops, partial products, divider operand setup
  logic         u0, lt0, gt0, aneg0, bneg0, big0;
  logic [W-1:0] sa0, sb0, amag0, bmag0, shr0;
  logic [SW-1:0] amt0;
  side_t        side1_d;

  assign u0    = au0_q || bu0_q;
  assign sa0   = u0 ? ua0_q : {~ua0_q[W-1], ua0_q[W-2:0]};
  assign sb0   = u0 ? ub0_q : {~ub0_q[W-1], ub0_q[W-2:0]};
  assign lt0   = sa0 < sb0;
  assign gt0   = sa0 > sb0;
  assign aneg0 = !u0 && ua0_q[W-1];
  assign bneg0 = !u0 && ub0_q[W-1];
  assign amag0 = aneg0 ? (~ua0_q + 1'b1) : ua0_q;
  assign bmag0 = bneg0 ? (~ub0_q + 1'b1) : ub0_q;
  assign big0  = ub0_q >= W'(W);
  assign amt0  = ub0_q[SW-1:0];
  assign shr0  = au0_q ? (ua0_q >> amt0) : W'($signed(ua0_q) >>> amt0);

  always_comb begin
    side1_d      = '0;
    side1_d.cmd  = cmd0_q;
    side1_d.dz   = (ub0_q == '0);
    side1_d.qneg = aneg0 ^ bneg0;
    side1_d.rneg = aneg0;
    unique case (cmd0_q)
      cita_pkg::CMD_MUL: side1_d.ru = u0;
      cita_pkg::CMD_DIV, cita_pkg::CMD_MOD: begin
        side1_d.ru  = u0;
        side1_d.err = side1_d.dz && ev0_q;
      end
      cita_pkg::CMD_ADD: begin side1_d.res = ua0_q + ub0_q; side1_d.ru = u0; end
      cita_pkg::CMD_SUB: begin side1_d.res = ua0_q - ub0_q; side1_d.ru = u0; end
      cita_pkg::CMD_SHL: begin
        side1_d.ru  = au0_q;
        side1_d.res = big0 ? '0 : (ua0_q << amt0);
      end
      cita_pkg::CMD_SHR: begin
        side1_d.ru  = au0_q;
        side1_d.res = big0 ? {W{!au0_q && ua0_q[W-1]}} : shr0;
      end
      cita_pkg::CMD_LT: side1_d.res = W'(lt0);
      cita_pkg::CMD_LE: side1_d.res = W'(!gt0);
      cita_pkg::CMD_GT: side1_d.res = W'(gt0);
      cita_pkg::CMD_GE: side1_d.res = W'(!lt0);
      cita_pkg::CMD_EQ: side1_d.res = W'(ua0_q == ub0_q);
      cita_pkg::CMD_NE: side1_d.res = W'(ua0_q != ub0_q);
      cita_pkg::CMD_AND: begin side1_d.res = ua0_q & ub0_q; side1_d.ru = u0; end
      cita_pkg::CMD_XOR: begin side1_d.res = ua0_q ^ ub0_q; side1_d.ru = u0; end
      cita_pkg::CMD_OR:  begin side1_d.res = ua0_q | ub0_q; side1_d.ru = u0; end
      cita_pkg::CMD_LAND: side1_d.res = W'((ua0_q != '0) && (ub0_q != '0));
      cita_pkg::CMD_LOR:  side1_d.res = W'((ua0_q != '0) || (ub0_q != '0));
      cita_pkg::CMD_NEG:   begin side1_d.res = '0 - ua0_q; side1_d.ru = au0_q; end
      cita_pkg::CMD_COMPL: begin side1_d.res = ~ua0_q; side1_d.ru = au0_q; end
      cita_pkg::CMD_LNOT:  side1_d.res = W'(ua0_q == '0);
      default: side1_d.res = '0;
    endcase
  end

  logic          v1_q;
  side_t         side1_q;
  logic [2*L-1:0] p0_q;
  logic [HB-1:0] p1_q, p2_q;
  logic [W-1:0]  n1_q, d1_q;
  logic [2*L-1:0] p1_full, p2_full;

  assign p1_full = (2*L)'(ua0_q[L-1:0] * ub0_q[W-1:L]);
  assign p2_full = (2*L)'(ua0_q[W-1:L] * ub0_q[L-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side1_d;
      p0_q    <= ua0_q[L-1:0] * ub0_q[L-1:0];
      p1_q    <= p1_full[HB-1:0];
      p2_q    <= p2_full[HB-1:0];
      n1_q    <= amag0;
      d1_q    <= bmag0;
    end
  end

  // product sum folds into the side info entering the divider
  side_t        side2_in;
  logic [HB-1:0] cross1;

  assign cross1 = p1_q + p2_q;
  always_comb begin
    side2_in = side1_q;
    if (side1_q.cmd == cita_pkg::CMD_MUL) begin
      side2_in.res = p0_q[W-1:0] + {cross1, {L{1'b0}}};
    end
  end

  // restoring divider, one quotient bit per stage
  logic         dv_q  [W];
  logic [W-1:0] rem_q [W];
  logic [W-1:0] nq_q  [W];
  logic [W-1:0] dd_q  [W];
  side_t        sd_q  [W];

  logic [W-1:0] rem_src [W];
  logic [W-1:0] nq_src  [W];
  logic [W-1:0] dd_src  [W];
  logic [W:0]   trial   [W];
  logic [W:0]   diff    [W];
  logic [W-1:0] rem_d   [W];
  logic [W-1:0] nq_d    [W];

  always_comb begin
    rem_src[0] = '0;
    nq_src[0]  = n1_q;
    dd_src[0]  = d1_q;
    for (int k = 1; k < W; k++) begin
      rem_src[k] = rem_q[k-1];
      nq_src[k]  = nq_q[k-1];
      dd_src[k]  = dd_q[k-1];
    end
    for (int k = 0; k < W; k++) begin
      trial[k] = {rem_src[k], nq_src[k][W-1]};
      diff[k]  = trial[k] - {1'b0, dd_src[k]};
      if (!diff[k][W]) begin
        rem_d[k] = diff[k][W-1:0];
        nq_d[k]  = {nq_src[k][W-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[k][W-1:0];
        nq_d[k]  = {nq_src[k][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < W; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      dv_q[0] <= v1_q;
      for (int k = 1; k < W; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side2_in;
      for (int k = 0; k < W; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
        dd_q[k]  <= dd_src[k];
      end
      for (int k = 1; k < W; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // final select, sign fix and extension to the port width
  side_t        sf;
  logic [W-1:0] quo_f, rmd_f, res_f;

  assign sf    = sd_q[W-1];
  assign quo_f = sf.qneg ? (~nq_q[W-1] + 1'b1) : nq_q[W-1];
  assign rmd_f = sf.rneg ? (~rem_q[W-1] + 1'b1) : rem_q[W-1];

  always_comb begin
    priority if (sf.cmd == cita_pkg::CMD_DIV) begin
      res_f = sf.dz ? '0 : quo_f;
    end else if (sf.cmd == cita_pkg::CMD_MOD) begin
      res_f = sf.dz ? '0 : rmd_f;
    end else begin
      res_f = sf.res;
    end
  end

  logic        out_v_q;
  logic [63:0] res_q;
  logic        ru_q, err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= sf.ru ? 64'(res_f) : 64'($signed(res_f));
      ru_q  <= sf.ru;
      err_q <= sf.err;
    end
  end

  assign out_valid_o       = out_v_q;
  assign result_value_o    = res_q;
  assign result_unsigned_o = ru_q;
  assign divide_error_o    = err_q;

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> result_value_o == 64'd0)
    else $error("divide error with nonzero result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting output word");

  a_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_unsigned_o |-> (result_value_o >> W) == 64'd0)
    else $error("unsigned result not zero extended");

endmodule

>>> sim/c_intmax_typed_alu_core_tb.sv
// ----------------------------------------------------------------------------
// c_intmax_typed_alu_core_tb
// Drives typed integer ALU operations through the core with random gaps on
// both channels and checks every result word against a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_intmax_typed_alu_core_tb;

  localparam int unsigned VW        = 64;
  localparam int unsigned LATENCY   = VW + 3;
  localparam int unsigned MAX_CYC   = 600000;
  localparam logic [63:0] MIN_NEG   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] value;
    logic        uns_flag;
    logic        div_err;
  } alu_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  cmd_i = '0;
  logic [63:0] a_value_i = '0;
  logic        a_unsigned_i = 1'b0;
  logic [63:0] b_value_i = '0;
  logic        b_unsigned_i = 1'b0;
  logic        evaluating_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_value_o;
  logic        result_unsigned_o;
  logic        divide_error_o;

  alu_result_t result_q[$];
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned cyc_cnt = 0;
  bit          hold_off = 1'b0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;

  c_intmax_typed_alu_core #(.VALUE_WIDTH(VW)) dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor: one operation to one result word
  function automatic alu_result_t predict_alu(logic [4:0] op, logic [63:0] a, logic au,
                                              logic [63:0] b, logic bu, logic ev);
    alu_result_t      res;
    logic             u;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic [63:0]      r;
    u  = au | bu;
    sa = a;
    sb = b;
    r  = '0;
    res.uns_flag = 1'b0;
    res.div_err = 1'b0;
    case (op)
      cita_pkg::CMD_MUL: begin r = a * b; res.uns_flag = u; end
      cita_pkg::CMD_DIV, cita_pkg::CMD_MOD: begin
        res.uns_flag = u;
        if (b == 0) begin
          res.div_err = ev;
        end else if (u) begin
          r = (op == cita_pkg::CMD_DIV) ? a / b : a % b;
        end else if (a == MIN_NEG && b == '1) begin
          r = (op == cita_pkg::CMD_DIV) ? a : '0;
        end else begin
          r = (op == cita_pkg::CMD_DIV) ? sa / sb : sa % sb;
        end
      end
      cita_pkg::CMD_ADD: begin r = a + b; res.uns_flag = u; end
      cita_pkg::CMD_SUB: begin r = a - b; res.uns_flag = u; end
      cita_pkg::CMD_SHL: begin
        res.uns_flag = au;
        r = (b >= VW) ? '0 : a << b[5:0];
      end
      cita_pkg::CMD_SHR: begin
        res.uns_flag = au;
        if (b >= VW) r = (!au && a[63]) ? '1 : '0;
        else if (!au) r = sa >>> b[5:0];
        else r = a >> b[5:0];
      end
      cita_pkg::CMD_LT: r = u ? 64'(a < b) : 64'(sa < sb);
      cita_pkg::CMD_LE: r = u ? 64'(a <= b) : 64'(sa <= sb);
      cita_pkg::CMD_GT: r = u ? 64'(a > b) : 64'(sa > sb);
      cita_pkg::CMD_GE: r = u ? 64'(a >= b) : 64'(sa >= sb);
      cita_pkg::CMD_EQ: r = 64'(a == b);
      cita_pkg::CMD_NE: r = 64'(a != b);
      cita_pkg::CMD_AND: begin r = a & b; res.uns_flag = u; end
      cita_pkg::CMD_XOR: begin r = a ^ b; res.uns_flag = u; end
      cita_pkg::CMD_OR: begin r = a | b; res.uns_flag = u; end
      cita_pkg::CMD_LAND: r = 64'(a != 0 && b != 0);
      cita_pkg::CMD_LOR: r = 64'(a != 0 || b != 0);
      cita_pkg::CMD_NEG: begin r = -a; res.uns_flag = au; end
      cita_pkg::CMD_COMPL: begin r = ~a; res.uns_flag = au; end
      cita_pkg::CMD_LNOT: r = 64'(a == 0);
      default: r = '0;
    endcase
    res.value = r;
    return res;
  endfunction

  // send one word, predicting its result; valid stays up for a back-to-back word
  task automatic send_word(logic [4:0] op, logic [63:0] a, logic au,
                           logic [63:0] b, logic bu, logic ev);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    a_value_i    <= a;
    a_unsigned_i <= au;
    b_value_i    <= b;
    b_unsigned_i <= bu;
    evaluating_i <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    result_q.push_back(predict_alu(op, a, au, b, bu, ev));
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // mix of edge values and plain random operands
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return MIN_NEG;
      3: return MAX_POS;
      4: return 64'($urandom_range(0, 70));
      5: return -64'($urandom_range(1, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver stall pattern
  always begin
    int unsigned wait_cyc;
    @(negedge clk_i);
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (rx_gaps) begin
      wait_cyc = $urandom_range(0, 19);
      if (wait_cyc > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cyc - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_cnt++;
      if (result_q.size() == 0) begin
        $error("result word with no expectation: value %h", result_value_o);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (result_value_o !== want.value) begin
          $error("result_value exp %h got %h", want.value, result_value_o);
          err_cnt++;
        end
        if (result_unsigned_o !== want.uns_flag) begin
          $error("result_unsigned exp %b got %b", want.uns_flag, result_unsigned_o);
          err_cnt++;
        end
        if (divide_error_o !== want.div_err) begin
          $error("divide_error exp %b got %b", want.div_err, divide_error_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > MAX_CYC) begin
      $display("timeout after %0d cycles", cyc_cnt);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(cita_pkg::CMD_MUL, MAX_POS, 1'b0, 64'd2, 1'b0, 1'b1);
    send_word(cita_pkg::CMD_MUL, '1, 1'b1, '1, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_DIV, 64'd7, 1'b0, '0, 1'b0, 1'b1);
    send_word(cita_pkg::CMD_DIV, 64'd7, 1'b1, '0, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_MOD, 64'd7, 1'b0, '0, 1'b1, 1'b1);
    send_word(cita_pkg::CMD_DIV, MIN_NEG, 1'b0, '1, 1'b0, 1'b1);
    send_word(cita_pkg::CMD_MOD, MIN_NEG, 1'b0, '1, 1'b0, 1'b1);
    send_word(cita_pkg::CMD_DIV, MIN_NEG, 1'b1, '1, 1'b0, 1'b1);
    send_word(cita_pkg::CMD_MOD, -64'd7, 1'b0, 64'd2, 1'b0, 1'b1);
    send_word(cita_pkg::CMD_ADD, MAX_POS, 1'b0, 64'd1, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_SUB, '0, 1'b0, 64'd1, 1'b1, 1'b0);
    send_word(cita_pkg::CMD_SHL, 64'd1, 1'b0, 64'd63, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_SHL, 64'd1, 1'b1, 64'd64, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_SHR, MIN_NEG, 1'b0, 64'd64, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_SHR, MIN_NEG, 1'b0, 64'd4, 1'b1, 1'b0);
    send_word(cita_pkg::CMD_SHR, MIN_NEG, 1'b1, '1, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_LT, '1, 1'b0, 64'd0, 1'b0, 1'b0);
    send_word(cita_pkg::CMD_LT, '1, 1'b1, 64'd0, 1'b0, 1'b0);
    for (int op = cita_pkg::CMD_LE; op <= cita_pkg::CMD_LNOT; op++)
      send_word(op[4:0], MIN_NEG, 1'b0, MAX_POS, 1'b0, 1'b1);
    send_word(5'd21, '1, 1'b1, '1, 1'b1, 1'b1);
    send_word(5'd31, '1, 1'b0, '0, 1'b0, 1'b1);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_word(5'($urandom_range(0, 31) < 29 ? $urandom_range(0, 20) : $urandom_range(21, 31)),
                pick_operand(), 1'($urandom), pick_operand(), 1'($urandom), 1'($urandom));
  endtask

  // receiver holds off while words arrive back to back, so the pipeline fills
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        tx_gaps  = 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
        tx_gaps  = 1'b1;
      end
      test_random(150);
    join
  endtask

  task automatic test_no_gaps();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random(200);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    int unsigned drain;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(700);
    test_backpressure();
    test_no_gaps();
    test_random(700);
    in_valid_i <= 1'b0;
    drain = 0;
    while (result_q.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY + 40) @(posedge clk_i);
    if (result_q.size() != 0) begin
      $error("%0d expected result words never arrived", result_q.size());
      err_cnt++;
    end
    $display("ran %0d words through all %0d operations plus unknown codes, %0d checked",
             sent_cnt, cita_pkg::CMD_LNOT + 1, got_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
